// ===== design/resample_obligation_tracker_core_assert.svh =====
// Assertion macros shared by the tracker modules.
// Simulation builds get the concurrent checks, synthesis builds get nothing.
`ifndef RESAMPLE_OBLIGATION_TRACKER_CORE_ASSERT_SVH
`define RESAMPLE_OBLIGATION_TRACKER_CORE_ASSERT_SVH

`ifndef SYNTHESIS

// A property that must hold on every clock edge outside reset.
`define ROT_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("tracker check failed");

// A condition that must be followed by a consequence on the next edge.
`define ROT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tracker sequence check failed");

`else

`define ROT_ASSERT(lbl, clk, rst_n, prop)
`define ROT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== design/rot_pkg.sv =====
package rot_pkg;

  // Field widths of the stream payloads.
  localparam int CMD_W      = 3;
  localparam int KIND_W     = 2;
  localparam int CODE_W     = 2;
  localparam int EXPIRY_W   = 11;
  localparam int OUT_CNT_W  = 32;
  localparam int NUM_CTR    = 7;
  localparam int IN_DATA_W  = 8;
  localparam int OUT_DATA_W = 232;

  // Default width of the internal event counters.
  localparam int COUNTER_BITS_DEFAULT = 32;

  // Allowed range and reset value of the expiry register.
  localparam logic [EXPIRY_W-1:0] EXPIRY_MIN   = 11'd100;
  localparam logic [EXPIRY_W-1:0] EXPIRY_MAX   = 11'd2000;
  localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = 11'd500;

  // Register index of the expiry setting.
  localparam logic REG_EXPIRY = 1'b0;

  // Commands carried by an input beat.
  typedef enum logic [CMD_W-1:0] {
    CMD_OBSERVE  = 3'd0,
    CMD_RELEASED = 3'd1,
    CMD_CAPTURE  = 3'd2,
    CMD_OUTCOME  = 3'd3,
    CMD_CANCEL   = 3'd4,
    CMD_TICK     = 3'd5
  } cmd_e;

  // Result codes; observe, release and capture share the numeric values.
  localparam logic [CODE_W-1:0] CODE_NONE      = 2'd0;
  localparam logic [CODE_W-1:0] CODE_COALESCED = 2'd1;
  localparam logic [CODE_W-1:0] CODE_CREATED   = 2'd2;
  localparam logic [CODE_W-1:0] CODE_RESAMPLE  = 2'd1;
  localparam logic [CODE_W-1:0] CODE_FALLBACK  = 2'd2;

  // Capture kind that needs no resample bookkeeping.
  localparam logic [KIND_W-1:0] KIND_NORMAL = 2'd0;

  // Event counter slots.
  typedef enum logic [2:0] {
    CTR_CREATED    = 3'd0,
    CTR_COALESCED  = 3'd1,
    CTR_DISPATCHED = 3'd2,
    CTR_FALLBACK   = 3'd3,
    CTR_FULFILLED  = 3'd4,
    CTR_COPY_FAIL  = 3'd5,
    CTR_CANCELLED  = 3'd6
  } ctr_e;

  // One decoded input item.
  typedef struct packed {
    cmd_e              cmd;
    logic              pool_at_cap;
    logic              conv_in_flight;
    logic              capture_queued;
    logic              adapter_held;
    logic [KIND_W-1:0] capture_kind;
    logic              copied;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [NUM_CTR-1:0][OUT_CNT_W-1:0] counts;
    logic                              obligation_open;
    logic [CODE_W-1:0]                 result_code;
  } res_t;

endpackage

// ===== design/resample_obligation_tracker_core.sv =====
// Channel   | Direction | Beat contents
// ----------+-----------+------------------------------------------------------------
// s_axis    | in        | tuser: cmd; tdata: pool_at_cap, conv_in_flight,
//           |           |   capture_queued, adapter_held, capture_kind, copied
// m_axis    | out       | tdata: result_code, obligation_open, seven event counts
// APB       | in/out    | expiry_ms at byte address 0
//
// One beat in and one result out per cycle while the result side is ready; an input
// beat is held in the input register, then its result in the result register.
// Reset clears the obligation state, the counters and both stage valids, and loads
// expiry_ms with 500. A stalled result holds the state, while the input register
// still takes one more beat; the input side stalls only when it holds that beat too.
module resample_obligation_tracker_core #(
  parameter int COUNTER_BITS = rot_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // Input stream.
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // [0] pool_at_cap, [1] conv_in_flight, [2] capture_queued,
  // [3] adapter_held, [5:4] capture_kind, [6] copied, [7] zero
  input  logic [rot_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  // [2:0] cmd
  input  logic [rot_pkg::CMD_W-1:0]         s_axis_tuser_i,
  // Result stream.
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // [1:0] result_code, [2] obligation_open, [34:3] count_created,
  // [66:35] count_coalesced, [98:67] count_dispatched, [130:99] count_fallback,
  // [162:131] count_fulfilled, [194:163] count_copy_fail,
  // [226:195] count_cancelled, [231:227] zero
  output logic [rot_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  // Configuration port.
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [2:0]                        paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  logic [rot_pkg::EXPIRY_W-1:0] expiry;
  logic                         item_valid;
  rot_pkg::in_item_t            item;
  logic                         take;
  rot_pkg::res_t                res;

  rot_cfg u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .expiry_o (expiry)
  );

  rot_in_reg u_in_reg (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .item_valid_o    (item_valid),
    .item_o          (item),
    .take_i          (take)
  );

  rot_engine #(
    .COUNTER_BITS (COUNTER_BITS)
  ) u_engine (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_valid),
    .item_i       (item),
    .take_o       (take),
    .expiry_i     (expiry),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .res_o        (res)
  );

  // Pack the result beat, lowest field first.
  assign m_axis_tdata_o = rot_pkg::OUT_DATA_W'(res);

endmodule

// ===== design/rot_cfg.sv =====
// APB register block holding the expiry setting.
module rot_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output logic [rot_pkg::EXPIRY_W-1:0]  expiry_o
);

  logic [rot_pkg::EXPIRY_W-1:0] expiry_q, expiry_d;
  logic [rot_pkg::EXPIRY_W-1:0] wval;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wval   = pwdata[rot_pkg::EXPIRY_W-1:0];
  assign wr_en  = psel && penable && pwrite && pready && (paddr[2] == rot_pkg::REG_EXPIRY);

  // Out-of-range writes leave the register untouched.
  always_comb begin
    expiry_d = expiry_q;
    if (wr_en && wval >= rot_pkg::EXPIRY_MIN && wval <= rot_pkg::EXPIRY_MAX) begin
      expiry_d = wval;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expiry_q <= rot_pkg::EXPIRY_RESET;
    end else begin
      expiry_q <= expiry_d;
    end
  end

  // Read back the register, zero elsewhere.
  always_comb begin
    prdata = '0;
    if (paddr[2] == rot_pkg::REG_EXPIRY) begin
      prdata = 32'(expiry_q);
    end
  end

  assign expiry_o = expiry_q;

endmodule

// ===== design/rot_in_reg.sv =====
// Input register: captures one beat and holds it until the engine takes it.
module rot_in_reg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [rot_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  input  logic [rot_pkg::CMD_W-1:0]        s_axis_tuser_i,
  output logic                             item_valid_o,
  output rot_pkg::in_item_t                item_o,
  input  logic                             take_i
);

  logic              valid_q, valid_d;
  rot_pkg::in_item_t item_q;
  logic              load;

  // The slot frees up in the same cycle the engine takes the held item.
  assign s_axis_tready_o = !valid_q || take_i;
  assign load            = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (take_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // Payload register, unpacked from the beat.
  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.cmd            <= rot_pkg::cmd_e'(s_axis_tuser_i);
      item_q.pool_at_cap    <= s_axis_tdata_i[0];
      item_q.conv_in_flight <= s_axis_tdata_i[1];
      item_q.capture_queued <= s_axis_tdata_i[2];
      item_q.adapter_held   <= s_axis_tdata_i[3];
      item_q.capture_kind   <= s_axis_tdata_i[5:4];
      item_q.copied         <= s_axis_tdata_i[6];
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ===== design/rot_engine.sv =====
`include "resample_obligation_tracker_core_assert.svh"

// Obligation state, event counters and result register.
module rot_engine #(
  parameter int COUNTER_BITS = rot_pkg::COUNTER_BITS_DEFAULT
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            item_valid_i,
  input  rot_pkg::in_item_t               item_i,
  output logic                            take_o,
  input  logic [rot_pkg::EXPIRY_W-1:0]    expiry_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output rot_pkg::res_t                   res_o
);

  localparam int NumCtr = rot_pkg::NUM_CTR;

  logic                                    outstanding_q, outstanding_d;
  logic                                    awaiting_q, awaiting_d;
  logic                                    fallback_q, fallback_d;
  logic [rot_pkg::EXPIRY_W-1:0]            time_left_q, time_left_d;
  logic [NumCtr-1:0][COUNTER_BITS-1:0]     cnt_q, cnt_d;
  logic [NumCtr-1:0]                       bump;
  logic [rot_pkg::CODE_W-1:0]              code_q, code_d;
  logic                                    out_valid_q, out_valid_d;
  logic                                    qualify;
  logic                                    is_open;

  // Take the held item whenever the result slot is free or being emptied.
  assign take_o = item_valid_i && (!out_valid_q || out_ready_i);

  assign qualify = item_i.pool_at_cap && item_i.conv_in_flight &&
                   item_i.capture_queued && !item_i.adapter_held;
  assign is_open = outstanding_q || awaiting_q;

  // Command decode and next obligation state.
  always_comb begin
    outstanding_d = outstanding_q;
    awaiting_d    = awaiting_q;
    fallback_d    = fallback_q;
    time_left_d   = time_left_q;
    bump          = '0;
    code_d        = rot_pkg::CODE_NONE;
    unique case (item_i.cmd)
      rot_pkg::CMD_OBSERVE: begin
        if (qualify) begin
          if (is_open) begin
            bump[rot_pkg::CTR_COALESCED] = 1'b1;
            code_d = rot_pkg::CODE_COALESCED;
          end else begin
            outstanding_d = 1'b1;
            time_left_d   = expiry_i;
            bump[rot_pkg::CTR_CREATED] = 1'b1;
            code_d = rot_pkg::CODE_CREATED;
          end
        end
      end
      rot_pkg::CMD_RELEASED: begin
        if (outstanding_q) begin
          outstanding_d = 1'b0;
          awaiting_d    = 1'b1;
          fallback_d    = (time_left_q == '0);
          if (time_left_q == '0) begin
            bump[rot_pkg::CTR_FALLBACK] = 1'b1;
            code_d = rot_pkg::CODE_FALLBACK;
          end else begin
            bump[rot_pkg::CTR_DISPATCHED] = 1'b1;
            code_d = rot_pkg::CODE_RESAMPLE;
          end
        end
      end
      rot_pkg::CMD_CAPTURE: begin
        if (awaiting_q) begin
          awaiting_d = 1'b0;
          code_d = fallback_q ? rot_pkg::CODE_FALLBACK : rot_pkg::CODE_RESAMPLE;
        end
      end
      rot_pkg::CMD_OUTCOME: begin
        if (item_i.capture_kind != rot_pkg::KIND_NORMAL) begin
          fallback_d = 1'b0;
          if (item_i.copied) begin
            bump[rot_pkg::CTR_FULFILLED] = 1'b1;
          end else begin
            bump[rot_pkg::CTR_COPY_FAIL] = 1'b1;
          end
        end
      end
      rot_pkg::CMD_CANCEL: begin
        bump[rot_pkg::CTR_CANCELLED] = is_open;
        outstanding_d = 1'b0;
        awaiting_d    = 1'b0;
        fallback_d    = 1'b0;
      end
      rot_pkg::CMD_TICK: begin
        if (time_left_q != '0) begin
          time_left_d = time_left_q - 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  // Saturating counter updates.
  always_comb begin
    for (int i = 0; i < NumCtr; i++) begin
      if (bump[i] && (cnt_q[i] != '1)) begin
        cnt_d[i] = cnt_q[i] + COUNTER_BITS'(1);
      end else begin
        cnt_d[i] = cnt_q[i];
      end
    end
  end

  // Result slot occupancy.
  always_comb begin
    out_valid_d = out_valid_q;
    if (take_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // State only moves when an item is taken, so it stays put while a result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outstanding_q <= 1'b0;
      awaiting_q    <= 1'b0;
      fallback_q    <= 1'b0;
      time_left_q   <= '0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (take_o) begin
        outstanding_q <= outstanding_d;
        awaiting_q    <= awaiting_d;
        fallback_q    <= fallback_d;
        time_left_q   <= time_left_d;
        cnt_q         <= cnt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o) begin
      code_q <= code_d;
    end
  end

  // Result fields: the code register plus the state left by the item.
  assign out_valid_o           = out_valid_q;
  assign res_o.result_code     = code_q;
  assign res_o.obligation_open = outstanding_q || awaiting_q;

  generate
    for (genvar g = 0; g < NumCtr; g++) begin : g_cnt_out
      if (COUNTER_BITS >= rot_pkg::OUT_CNT_W) begin : g_trunc
        assign res_o.counts[g] = cnt_q[g][rot_pkg::OUT_CNT_W-1:0];
      end else begin : g_ext
        assign res_o.counts[g] = rot_pkg::OUT_CNT_W'(cnt_q[g]);
      end
    end
  endgenerate

  // An obligation is either waiting for release or for capture, never both.
  `ROT_ASSERT(a_phase_excl, clk_i, rst_ni, !(outstanding_q && awaiting_q))
  // The countdown never holds more than the largest expiry setting.
  `ROT_ASSERT(a_time_bound, clk_i, rst_ni, time_left_q <= rot_pkg::EXPIRY_MAX)
  // Counters stay frozen while a finished result is stalled.
  `ROT_ASSERT_NEXT(a_cnt_hold, clk_i, rst_ni, out_valid_q && !out_ready_i, $stable(cnt_q))
  // Releasing an outstanding obligation moves it to the capture phase.
  `ROT_ASSERT_NEXT(a_release, clk_i, rst_ni,
                   take_o && (item_i.cmd == rot_pkg::CMD_RELEASED) && outstanding_q,
                   awaiting_q && !outstanding_q)

endmodule

// ===== dv/resample_obligation_tracker_checker.sv =====
`timescale 1ns / 1ps
module resample_obligation_tracker_checker
  import rot_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid_i,
  input  logic                  s_axis_tready_i,
  input  logic [IN_DATA_W-1:0]  s_axis_tdata_i,
  input  logic [CMD_W-1:0]      s_axis_tuser_i,
  input  logic                  m_axis_tvalid_i,
  input  logic                  m_axis_tready_i,
  input  logic [OUT_DATA_W-1:0] m_axis_tdata_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [2:0]            paddr,
  input  logic [31:0]           pwdata,
  input  logic [31:0]           prdata,
  input  logic                  pready,
  output int                    fail_count,
  output int                    results_due
);

  // Shadow copy of the tracker state and its expiry setting.
  logic [EXPIRY_W-1:0]  expiry_setting;
  logic                 outstanding_q;
  logic                 awaiting_q;
  logic                 fallback_q;
  logic [EXPIRY_W-1:0]  ms_left;
  logic [OUT_CNT_W-1:0] tally [NUM_CTR];

  // Results predicted for accepted beats, oldest first.
  res_t due_results [$];

  string ctr_label [NUM_CTR];

  initial begin
    fail_count   = 0;
    results_due  = 0;
    ctr_label[0] = "count_created";
    ctr_label[1] = "count_coalesced";
    ctr_label[2] = "count_dispatched";
    ctr_label[3] = "count_fallback";
    ctr_label[4] = "count_fulfilled";
    ctr_label[5] = "count_copy_fail";
    ctr_label[6] = "count_cancelled";
  end

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  // Counters hold at all ones instead of wrapping.
  task automatic bump(input ctr_e slot);
    if (tally[slot] != '1) begin
      tally[slot] = tally[slot] + 1'b1;
    end
  endtask

  // Advances the shadow state by one command and builds the result it yields.
  task automatic apply_command(input logic [CMD_W-1:0] op,
                               input logic [IN_DATA_W-1:0] bits,
                               output res_t r);
    logic              qualifies;
    logic [KIND_W-1:0] kind;
    // tdata: [0] pool_at_cap, [1] conv_in_flight, [2] capture_queued,
    // [3] adapter_held, [5:4] capture_kind, [6] copied.
    qualifies = bits[0] && bits[1] && bits[2] && !bits[3];
    kind      = bits[5:4];
    r         = '0;
    r.result_code = CODE_NONE;
    case (op)
      CMD_OBSERVE: begin
        if (qualifies) begin
          if (outstanding_q || awaiting_q) begin
            bump(CTR_COALESCED);
            r.result_code = CODE_COALESCED;
          end else begin
            outstanding_q = 1'b1;
            ms_left       = expiry_setting;
            bump(CTR_CREATED);
            r.result_code = CODE_CREATED;
          end
        end
      end
      CMD_RELEASED: begin
        if (outstanding_q) begin
          outstanding_q = 1'b0;
          awaiting_q    = 1'b1;
          fallback_q    = (ms_left == '0);
          if (fallback_q) begin
            bump(CTR_FALLBACK);
            r.result_code = CODE_FALLBACK;
          end else begin
            bump(CTR_DISPATCHED);
            r.result_code = CODE_RESAMPLE;
          end
        end
      end
      CMD_CAPTURE: begin
        if (awaiting_q) begin
          awaiting_q    = 1'b0;
          r.result_code = fallback_q ? CODE_FALLBACK : CODE_RESAMPLE;
        end
      end
      CMD_OUTCOME: begin
        if (kind != KIND_NORMAL) begin
          fallback_q = 1'b0;
          if (bits[6]) begin
            bump(CTR_FULFILLED);
          end else begin
            bump(CTR_COPY_FAIL);
          end
        end
      end
      CMD_CANCEL: begin
        if (outstanding_q || awaiting_q) begin
          bump(CTR_CANCELLED);
        end
        outstanding_q = 1'b0;
        awaiting_q    = 1'b0;
        fallback_q    = 1'b0;
      end
      CMD_TICK: begin
        if (ms_left != '0) begin
          ms_left = ms_left - 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.obligation_open = outstanding_q || awaiting_q;
    for (int i = 0; i < NUM_CTR; i++) begin
      r.counts[i] = tally[i];
    end
  endtask

  // Watch the register port and both streams at every rising edge.
  always @(posedge clk_i or negedge rst_ni) begin
    res_t got;
    res_t want;
    res_t next_res;
    if (!rst_ni) begin
      expiry_setting = EXPIRY_RESET;
      outstanding_q  = 1'b0;
      awaiting_q     = 1'b0;
      fallback_q     = 1'b0;
      ms_left        = '0;
      for (int i = 0; i < NUM_CTR; i++) begin
        tally[i] = '0;
      end
      due_results.delete();
      results_due = 0;
    end else begin
      // Register access phase: apply writes, compare reads of the expiry.
      if (psel && penable && pready && (paddr[2] == REG_EXPIRY)) begin
        if (pwrite) begin
          if (pwdata[EXPIRY_W-1:0] >= EXPIRY_MIN && pwdata[EXPIRY_W-1:0] <= EXPIRY_MAX) begin
            expiry_setting = pwdata[EXPIRY_W-1:0];
          end
        end else begin
          check_field("expiry_ms", {{(32-EXPIRY_W){1'b0}}, expiry_setting}, prdata);
        end
      end

      // A result beat leaving can never belong to a beat entering this edge.
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        got = res_t'(m_axis_tdata_i[$bits(res_t)-1:0]);
        if (due_results.size() == 0) begin
          $error("result beat arrived with no expected result pending");
          fail_count++;
        end else begin
          want = due_results.pop_front();
          check_field("result_code", 32'(want.result_code), 32'(got.result_code));
          check_field("obligation_open", 32'(want.obligation_open),
                      32'(got.obligation_open));
          for (int i = 0; i < NUM_CTR; i++) begin
            check_field(ctr_label[i], want.counts[i], got.counts[i]);
          end
        end
        check_field("tdata_padding", '0, 32'(m_axis_tdata_i[OUT_DATA_W-1:$bits(res_t)]));
      end

      if (s_axis_tvalid_i && s_axis_tready_i) begin
        apply_command(s_axis_tuser_i, s_axis_tdata_i, next_res);
        due_results.push_back(next_res);
      end
      results_due = due_results.size();
    end
  end

endmodule

// ===== dv/resample_obligation_tracker_core_tb.sv =====
`timescale 1ns / 1ps
module resample_obligation_tracker_core_tb;
  import rot_pkg::*;

  localparam int RUN_LIMIT       = 400000;
  localparam int ITEMS_PER_PHASE = 430;
  localparam int DRAIN_CYCLES    = 6;

  localparam logic [2:0] EXPIRY_ADDR = {REG_EXPIRY, 2'b00};
  localparam logic [2:0] SPARE_ADDR  = {~REG_EXPIRY, 2'b00};

  // Command codes the block does not define.
  localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 3'd6;
  localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 3'd7;

  localparam logic [KIND_W-1:0] KIND_RESAMPLE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_FALLBACK = 2'd2;
  localparam logic [KIND_W-1:0] KIND_SPARE    = 2'd3;

  logic                  clk_i           = 1'b0;
  logic                  rst_ni          = 1'b0;
  logic                  s_axis_tvalid_i = 1'b0;
  logic                  s_axis_tready_o;
  logic [IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic [CMD_W-1:0]      s_axis_tuser_i  = '0;
  logic                  m_axis_tvalid_o;
  logic                  m_axis_tready_i = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                  psel            = 1'b0;
  logic                  penable         = 1'b0;
  logic                  pwrite          = 1'b0;
  logic [2:0]            paddr           = '0;
  logic [31:0]           pwdata          = '0;
  logic [31:0]           prdata;
  logic                  pready;

  int fail_count;
  int results_due;
  int cycle_count = 0;
  int items_sent  = 0;
  int send_idle_pct = 35;
  int recv_idle_pct = 51;
  int expiry_now    = int'(EXPIRY_RESET);

  resample_obligation_tracker_core dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  resample_obligation_tracker_checker result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .fail_count      (fail_count),
    .results_due     (results_due)
  );

  always #1 clk_i = ~clk_i;

  // The result side stalls at random according to the current phase.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Hard stop in case the handshake hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= RUN_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic logic [6:0] rand_bits();
    return 7'($urandom);
  endfunction

  // Sends one beat, idling first at random; returns at the accepting edge.
  task automatic send_beat(input logic [CMD_W-1:0] op, input logic [6:0] bits);
    logic rdy;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {1'b0, bits};
    do begin
      @(negedge clk_i);
      rdy = s_axis_tready_o;
      @(posedge clk_i);
    end while (!rdy);
    items_sent++;
  endtask

  task automatic observe(input logic pool_at_cap, input logic conv, input logic pend,
                         input logic retained);
    send_beat(CMD_OBSERVE, {3'b000, retained, pend, conv, pool_at_cap});
  endtask

  task automatic record_outcome(input logic [KIND_W-1:0] kind, input logic copied);
    send_beat(CMD_OUTCOME, {copied, kind, 4'($urandom)});
  endtask

  // A setup phase and an access phase, then the port is deselected.
  task automatic apb_xfer(input logic wr, input logic [2:0] addr, input logic [31:0] data);
    logic rdy;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      rdy = pready;
      @(posedge clk_i);
    end while (!rdy);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Lets every expected result drain before the registers are touched.
  task automatic wait_idle();
    s_axis_tvalid_i <= 1'b0;
    do begin
      @(negedge clk_i);
    end while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // Out-of-range and misaddressed writes must leave the expiry alone.
  task automatic set_expiry(input logic [EXPIRY_W-1:0] target);
    logic [31:0]         junk;
    logic [EXPIRY_W-1:0] bad;
    wait_idle();
    for (int k = 0; k < 4; k++) begin
      junk = $urandom;
      case (k)
        0: bad = EXPIRY_MIN - 1'b1;
        1: bad = EXPIRY_MAX + 1'b1;
        2: bad = '0;
        default: bad = '1;
      endcase
      apb_xfer(1'b1, EXPIRY_ADDR, {junk[31:EXPIRY_W], bad});
    end
    apb_xfer(1'b1, SPARE_ADDR, $urandom);
    apb_xfer(1'b0, EXPIRY_ADDR, '0);
    junk = $urandom;
    apb_xfer(1'b1, EXPIRY_ADDR, {junk[31:EXPIRY_W], target});
    apb_xfer(1'b0, EXPIRY_ADDR, '0);
    expiry_now = int'(target);
  endtask

  // A full obligation life cycle with random detours and boundary tick counts.
  task automatic run_obligation();
    int ticks;
    send_beat(CMD_OBSERVE, {rand_bits() & 7'b1110000} | 7'b0000111);
    repeat ($urandom_range(2)) send_beat(CMD_OBSERVE, rand_bits());
    if (expiry_now <= 200 && $urandom_range(2) == 0) begin
      ticks = expiry_now - 2 + $urandom_range(3);
    end else begin
      ticks = $urandom_range(8);
    end
    repeat (ticks) send_beat(CMD_TICK, rand_bits());
    if ($urandom_range(7) == 0) begin
      send_beat(CMD_CANCEL, rand_bits());
      return;
    end
    send_beat(CMD_RELEASED, rand_bits());
    if ($urandom_range(3) == 0) begin
      observe(1'b1, 1'b1, 1'b1, 1'b0);
    end
    if ($urandom_range(9) == 0) begin
      send_beat(CMD_CANCEL, rand_bits());
    end
    send_beat(CMD_CAPTURE, rand_bits());
    if ($urandom_range(5) == 0) begin
      record_outcome(KIND_NORMAL, 1'($urandom));
    end else begin
      record_outcome(KIND_W'($urandom_range(3, 1)), 1'($urandom));
    end
  endtask

  initial begin
    int start;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset value of the expiry register.
    apb_xfer(1'b0, EXPIRY_ADDR, '0);

    // Directed: commands with nothing open, each disqualifier, the full cycle.
    send_beat(CMD_TICK, '0);
    send_beat(CMD_RELEASED, '0);
    send_beat(CMD_CAPTURE, '0);
    record_outcome(KIND_NORMAL, 1'b1);
    record_outcome(KIND_SPARE, 1'b0);
    send_beat(CMD_CANCEL, '0);
    observe(1'b0, 1'b1, 1'b1, 1'b0);
    observe(1'b1, 1'b0, 1'b1, 1'b0);
    observe(1'b1, 1'b1, 1'b0, 1'b0);
    observe(1'b1, 1'b1, 1'b1, 1'b1);
    observe(1'b1, 1'b1, 1'b1, 1'b0);
    observe(1'b1, 1'b1, 1'b1, 1'b0);
    send_beat(CMD_TICK, '1);
    send_beat(CMD_RELEASED, '1);
    observe(1'b1, 1'b1, 1'b1, 1'b0);
    send_beat(CMD_CAPTURE, '1);
    record_outcome(KIND_RESAMPLE, 1'b1);
    record_outcome(KIND_FALLBACK, 1'b0);
    observe(1'b1, 1'b1, 1'b1, 1'b0);
    send_beat(CMD_CANCEL, '1);
    send_beat(CMD_UNUSED_LO, '1);
    send_beat(CMD_UNUSED_HI, '1);
    observe(1'b1, 1'b1, 1'b1, 1'b0);
    send_beat(CMD_RELEASED, '0);
    send_beat(CMD_CANCEL, '0);

    // Random phases: shortest expiry, longest expiry, then a short random one.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 35;
          recv_idle_pct = 51;
          set_expiry(EXPIRY_MIN);
        end
        1: begin
          send_idle_pct = 51;
          recv_idle_pct = 35;
          set_expiry(EXPIRY_MAX);
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
          set_expiry(EXPIRY_W'($urandom_range(160, 100)));
        end
      endcase
      start = items_sent;
      while (items_sent - start < ITEMS_PER_PHASE) begin
        if ($urandom_range(9) < 7) begin
          run_obligation();
        end else begin
          repeat ($urandom_range(4, 1)) send_beat(CMD_W'($urandom_range(7)), rand_bits());
        end
      end
    end

    wait_idle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/rot_pkg.sv
design/rot_cfg.sv
design/rot_in_reg.sv
design/rot_engine.sv
design/resample_obligation_tracker_core.sv
dv/resample_obligation_tracker_checker.sv
dv/resample_obligation_tracker_core_tb.sv
